// ===== design/comment_aware_code_line_counter_unit_macros.svh =====
// Assertion macros used by the line counter engine.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef COMMENT_AWARE_CODE_LINE_COUNTER_UNIT_MACROS_SVH
`define COMMENT_AWARE_CODE_LINE_COUNTER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CACL_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("line counter check failed");

`define CACL_ASSERT_SAME(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("line counter check failed");

`define CACL_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("line counter check failed");

`else

`define CACL_ASSERT_ALWAYS(lbl, cond)
`define CACL_ASSERT_SAME(lbl, ant, cons)
`define CACL_ASSERT_NEXT(lbl, ant, cons)

`endif

`endif

// ===== design/cacl_pkg.sv =====
package cacl_pkg;

    localparam int MAX_SYMBOL_LEN_DEF = 4;
    localparam int SKIP_W = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SINGLE_SYMBOL = 3'd0,
        REG_SINGLE_LEN    = 3'd1,
        REG_OPEN_SYMBOL   = 3'd2,
        REG_OPEN_LEN      = 3'd3,
        REG_CLOSE_SYMBOL  = 3'd4,
        REG_CLOSE_LEN     = 3'd5,
        REG_MIN_CHARS     = 3'd6
    } cfg_reg_idx_t;

    typedef struct packed {
        logic [31:0] single_symbol;
        logic [2:0]  single_len;
        logic [31:0] open_symbol;
        logic [2:0]  open_len;
        logic [31:0] close_symbol;
        logic [2:0]  close_len;
        logic [15:0] min_chars;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        single_symbol: 32'd12079,
        single_len:    3'd2,
        open_symbol:   32'd10799,
        open_len:      3'd2,
        close_symbol:  32'd12074,
        close_len:     3'd2,
        min_chars:     16'd0
    };

    typedef struct packed {
        logic [7:0] char_byte;
        logic       has_char;
        logic       line_end;
        logic       batch_start;
        logic       start_in_block;
        logic       batch_end;
    } in_req_t;

    typedef struct packed {
        logic        line_counted;
        logic [15:0] valid_lines;
        logic        in_block;
        logic        batch_last;
    } out_res_t;

    typedef enum logic [1:0] {
        KIND_MARK,
        KIND_BYTE,
        KIND_LINE
    } item_kind_t;

    typedef struct packed {
        in_req_t    req;
        item_kind_t kind;
    } front_item_t;

    typedef struct packed {
        logic        valid;
        front_item_t item;
    } front_status_t;

    typedef struct packed {
        logic     push;
        out_res_t data;
    } res_push_t;

    typedef enum logic {
        ST_IDLE,
        ST_FLUSH
    } eng_state_t;

    function automatic logic is_space(logic [7:0] b);
        return b inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
    endfunction

    // Returns the symbol length when it matches at the head of the window, else zero.
    function automatic logic [2:0] match_len(logic [31:0] sym, logic [2:0] len,
                                             logic [3:0][7:0] head, logic [3:0] avail,
                                             int max_len);
        logic ok;
        ok = (len != 3'd0) && (int'(len) <= 4) && (int'(len) <= max_len)
             && ({1'b0, len} <= avail);
        for (int i = 0; i < 4; i++) begin
            if ((i < int'(len)) && (head[i] != sym[8*i +: 8])) begin
                ok = 1'b0;
            end
        end
        return ok ? len : 3'd0;
    endfunction

endpackage

// ===== design/comment_aware_code_line_counter_unit.sv =====
// Comment-aware code line counter.
// Input side is a queue: drive item and raise push; the request is taken at a
// clock edge where push is high and full is low. One request carries at most one byte
// of source text with its line and batch marks.
// Result side is a queue too: while empty is low the oldest result sits on
// result, and pop takes it. One result is produced per request with line_end.
// Configuration is written through cfg_wr, cfg_idx and cfg_data; the user must
// write it only while the block is idle, which the block does not enforce.
// Indexes beyond the last register are ignored. Throughput: while the back
// end is idle, bytes stream at one per cycle. A line end holds the back end in
// its flush state while the bytes still held in the lookahead window (at most
// MAX_SYMBOL_LEN - 1) are examined, one position per cycle, and until its
// result enters the result queue; further requests wait meanwhile.
// Reset clears both queues, the line state and the line count, and loads the
// default symbols. When the receiver stalls, results wait in a two-entry
// queue, then the back end holds, and full rises once the input queue fills.
module comment_aware_code_line_counter_unit #(
    parameter int MAX_SYMBOL_LEN = cacl_pkg::MAX_SYMBOL_LEN_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  cacl_pkg::in_req_t                  item,
    output logic                               empty,
    input  logic                               pop,
    output cacl_pkg::out_res_t                 result,
    input  logic                               cfg_wr,
    input  logic [cacl_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [cacl_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import cacl_pkg::*;

    cfg_t          cfg_reg, cfg_next;
    front_status_t front;
    logic          take;
    res_push_t     res;
    logic          res_full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (cfg_idx)
                REG_SINGLE_SYMBOL: cfg_next.single_symbol = cfg_data;
                REG_SINGLE_LEN:    cfg_next.single_len = cfg_data[2:0];
                REG_OPEN_SYMBOL:   cfg_next.open_symbol = cfg_data;
                REG_OPEN_LEN:      cfg_next.open_len = cfg_data[2:0];
                REG_CLOSE_SYMBOL:  cfg_next.close_symbol = cfg_data;
                REG_CLOSE_LEN:     cfg_next.close_len = cfg_data[2:0];
                REG_MIN_CHARS:     cfg_next.min_chars = cfg_data[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    cacl_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .status (front),
        .take   (take)
    );

    cacl_engine #(
        .MAX_SYMBOL_LEN (MAX_SYMBOL_LEN)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .front    (front),
        .take     (take),
        .res      (res),
        .res_full (res_full)
    );

    cacl_res_queue u_res_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (res),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule

// ===== design/cacl_front.sv =====
module cacl_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  cacl_pkg::in_req_t      item,
    output cacl_pkg::front_status_t status,
    input  logic                   take
);
    import cacl_pkg::*;

    front_item_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]     count_reg, count_next;
    front_item_t           classified;
    logic                  wr_en;
    logic                  rd_en;

    always_comb
    begin
        classified.req = item;
        if (item.line_end)
        begin
            classified.kind = KIND_LINE;
        end
        else if (item.has_char)
        begin
            classified.kind = KIND_BYTE;
        end
        else
        begin
            classified.kind = KIND_MARK;
        end
    end

    assign full = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign wr_en = push && !full;
    assign rd_en = take && (count_reg != '0);

    assign status.valid = (count_reg != '0);
    assign status.item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== design/cacl_res_queue.sv =====
module cacl_res_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  cacl_pkg::res_push_t req,
    output logic                res_full,
    output logic                empty,
    input  logic                pop,
    output cacl_pkg::out_res_t  result
);
    import cacl_pkg::*;

    out_res_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              wr_en;
    logic              rd_en;

    assign res_full = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign wr_en = req.push && !res_full;
    assign rd_en = pop && !empty;
    assign result = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= req.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== design/cacl_engine.sv =====
`include "comment_aware_code_line_counter_unit_macros.svh"

module cacl_engine #(
    parameter int MAX_SYMBOL_LEN = cacl_pkg::MAX_SYMBOL_LEN_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cacl_pkg::cfg_t          cfg,
    input  cacl_pkg::front_status_t front,
    output logic                    take,
    output cacl_pkg::res_push_t     res,
    input  logic                    res_full
);
    import cacl_pkg::*;

    localparam int FILL_W = $clog2(MAX_SYMBOL_LEN + 1);
    localparam int IDX_W = (MAX_SYMBOL_LEN > 1) ? $clog2(MAX_SYMBOL_LEN) : 1;
    localparam int PAD_N = (MAX_SYMBOL_LEN > 4) ? MAX_SYMBOL_LEN : 4;

    eng_state_t                        state_reg, state_next;
    logic [MAX_SYMBOL_LEN-1:0][7:0]    win_reg, win_next;
    logic [FILL_W-1:0]                 fill_reg, fill_next;
    logic [SKIP_W-1:0]                 skip_reg, skip_next;
    logic                              block_reg, block_next;
    logic                              after_reg, after_next;
    logic                              rest_reg, rest_next;
    logic [15:0]                       char_cnt_reg, char_cnt_next;
    logic [15:0]                       line_cnt_reg, line_cnt_next;
    logic                              last_reg, last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            win_reg <= '0;
            fill_reg <= '0;
            skip_reg <= '0;
            block_reg <= 1'b0;
            after_reg <= 1'b0;
            rest_reg <= 1'b0;
            char_cnt_reg <= '0;
            line_cnt_reg <= '0;
            last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            win_reg <= win_next;
            fill_reg <= fill_next;
            skip_reg <= skip_next;
            block_reg <= block_next;
            after_reg <= after_next;
            rest_reg <= rest_next;
            char_cnt_reg <= char_cnt_next;
            line_cnt_reg <= line_cnt_next;
            last_reg <= last_next;
        end
    end

    always_comb
    begin
        logic [MAX_SYMBOL_LEN-1:0][7:0] cur_win;
        logic [FILL_W-1:0]              cur_fill;
        logic [PAD_N-1:0][7:0]          padded;
        logic                           do_proc;
        logic                           do_pop;
        logic                           counted;
        logic [2:0]                     ms;
        logic [2:0]                     mo;
        logic [2:0]                     mc;

        state_next = state_reg;
        win_next = win_reg;
        fill_next = fill_reg;
        skip_next = skip_reg;
        block_next = block_reg;
        after_next = after_reg;
        rest_next = rest_reg;
        char_cnt_next = char_cnt_reg;
        line_cnt_next = line_cnt_reg;
        last_next = last_reg;
        take = 1'b0;
        res.push = 1'b0;
        cur_win = win_reg;
        cur_fill = fill_reg;
        do_proc = 1'b0;
        do_pop = 1'b0;
        ms = '0;
        mo = '0;
        mc = '0;

        counted = (char_cnt_reg > cfg.min_chars);
        res.data.line_counted = counted;
        res.data.valid_lines = (counted && (line_cnt_reg != COUNT_MAX))
                               ? line_cnt_reg + 1'b1 : line_cnt_reg;
        res.data.in_block = block_reg;
        res.data.batch_last = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (front.valid)
                begin
                    take = 1'b1;
                    if (front.item.req.batch_start)
                    begin
                        line_cnt_next = '0;
                        block_next = front.item.req.start_in_block;
                        win_next = '0;
                        fill_next = '0;
                        skip_next = '0;
                        after_next = 1'b0;
                        rest_next = 1'b0;
                        char_cnt_next = '0;
                    end
                    if (front.item.kind != KIND_MARK && front.item.req.has_char && !rest_next)
                    begin
                        cur_win = win_next;
                        cur_fill = fill_next;
                        if (fill_next < FILL_W'(MAX_SYMBOL_LEN))
                        begin
                            cur_win[fill_next[IDX_W-1:0]] = front.item.req.char_byte;
                            cur_fill = fill_next + 1'b1;
                        end
                        win_next = cur_win;
                        fill_next = cur_fill;
                        do_proc = (cur_fill == FILL_W'(MAX_SYMBOL_LEN));
                    end
                    if (front.item.kind == KIND_LINE)
                    begin
                        state_next = ST_FLUSH;
                        last_next = front.item.req.batch_end;
                    end
                end
            end
            ST_FLUSH:
            begin
                if ((fill_reg != '0) && !rest_reg)
                begin
                    do_proc = 1'b1;
                end
                else if (!res_full)
                begin
                    res.push = 1'b1;
                    line_cnt_next = res.data.valid_lines;
                    win_next = '0;
                    fill_next = '0;
                    skip_next = '0;
                    after_next = 1'b0;
                    rest_next = 1'b0;
                    char_cnt_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // One head step of the lookahead window; symbols are checked in priority order.
        padded = '0;
        padded[MAX_SYMBOL_LEN-1:0] = cur_win;
        if (do_proc && (cur_fill != '0))
        begin
            if (skip_next != '0)
            begin
                skip_next = skip_next - 1'b1;
                do_pop = 1'b1;
            end
            else
            begin
                ms = match_len(cfg.single_symbol, cfg.single_len, padded[3:0],
                               4'(cur_fill), MAX_SYMBOL_LEN);
                mo = match_len(cfg.open_symbol, cfg.open_len, padded[3:0],
                               4'(cur_fill), MAX_SYMBOL_LEN);
                mc = match_len(cfg.close_symbol, cfg.close_len, padded[3:0],
                               4'(cur_fill), MAX_SYMBOL_LEN);
                if (ms != '0)
                begin
                    if (!block_next)
                    begin
                        rest_next = 1'b1;
                        fill_next = '0;
                    end
                    else
                    begin
                        after_next = 1'b1;
                        skip_next = SKIP_W'(ms - 3'd1);
                        do_pop = 1'b1;
                    end
                end
                else if (mo != '0)
                begin
                    block_next = 1'b1;
                    skip_next = SKIP_W'(mo - 3'd1);
                    do_pop = 1'b1;
                end
                else if (mc != '0)
                begin
                    block_next = 1'b0;
                    skip_next = SKIP_W'(mc - 3'd1);
                    do_pop = 1'b1;
                end
                else
                begin
                    if (!block_next && !after_next && !is_space(padded[0])
                        && (char_cnt_next != COUNT_MAX))
                    begin
                        char_cnt_next = char_cnt_next + 1'b1;
                    end
                    do_pop = 1'b1;
                end
            end
        end

        if (do_pop)
        begin
            for (int i = 0; i < MAX_SYMBOL_LEN - 1; i++)
            begin
                win_next[i] = cur_win[i + 1];
            end
            win_next[MAX_SYMBOL_LEN-1] = 8'h00;
            fill_next = cur_fill - 1'b1;
        end
    end

    `CACL_ASSERT_ALWAYS(a_fill_bound, fill_reg <= FILL_W'(MAX_SYMBOL_LEN - 1))
    `CACL_ASSERT_SAME(a_rest_empty, rest_reg, fill_reg == '0)
    `CACL_ASSERT_ALWAYS(a_skip_within_fill, skip_reg <= fill_reg)
    `CACL_ASSERT_NEXT(a_flush_done, (state_reg == ST_FLUSH) && (fill_reg == '0) && !res_full, (state_reg == ST_IDLE) && (char_cnt_reg == '0))

endmodule
